### sv/skrt_pkg.sv
package skrt_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [5:0] MAX_ENTRIES_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_HIT       = 3'd5,
    ST_MISS      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK
  } state_e;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] record_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_record;
    logic [5:0]  entry_count;
    logic        last;
  } rsp_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
    logic first;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic keq;
    logic peq;
    logic active;
    logic fin;
  } cell_flag_t;

endpackage

### sv/skrt_cell.sv
module skrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skrt_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occ_i,
  input  skrt_pkg::key_t       cmp_key_i,
  input  logic [31:0]          cmp_rec_i,
  input  skrt_pkg::key_t       op_key_i,
  input  logic [31:0]          op_rec_i,
  input  skrt_pkg::key_t       left_key_i,
  input  logic [31:0]          left_rec_i,
  input  logic                 left_lt_i,
  input  logic                 left_keq_i,
  input  logic                 left_active_i,
  input  skrt_pkg::key_t       right_key_i,
  input  logic [31:0]          right_rec_i,
  input  logic                 right_keq_i,
  output skrt_pkg::key_t       key_o,
  output logic [31:0]          rec_o,
  output skrt_pkg::cell_flag_t flag_o
);
  import skrt_pkg::*;

  key_t        key_q, key_d;
  logic [31:0] rec_q, rec_d;
  logic        lt_q, keq_q, peq_q, tok_q;
  logic        lt_d, keq_d, peq_d, tok_d;
  logic        active;

  always_comb begin
    lt_d  = lt_q;
    keq_d = keq_q;
    peq_d = peq_q;
    if (ctrl_i.cmp_en) begin
      keq_d = occ_i && (key_q == cmp_key_i);
      peq_d = keq_d && (rec_q == cmp_rec_i);
      lt_d  = occ_i && ((key_q < cmp_key_i) || (keq_d && (rec_q < cmp_rec_i)));
    end
  end

  // shift right on insert, left on remove; cells below the position hold
  always_comb begin
    key_d = key_q;
    rec_d = rec_q;
    if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d = op_key_i;
        rec_d = op_rec_i;
      end else begin
        key_d = left_key_i;
        rec_d = left_rec_i;
      end
    end else if (ctrl_i.rem && !lt_q) begin
      key_d = right_key_i;
      rec_d = right_rec_i;
    end
  end

  // read token: starts at the head of the matching run, walks right
  assign active = ctrl_i.first ? (keq_q && !left_keq_i) : tok_q;
  assign tok_d  = ctrl_i.step && left_active_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      keq_q <= 1'b0;
      peq_q <= 1'b0;
      tok_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      keq_q <= keq_d;
      peq_q <= peq_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rec_q <= rec_d;
  end

  assign key_o         = key_q;
  assign rec_o         = rec_q;
  assign flag_o.lt     = lt_q;
  assign flag_o.keq    = keq_q;
  assign flag_o.peq    = peq_q;
  assign flag_o.active = active;
  assign flag_o.fin    = active && !right_keq_i;

endmodule

### sv/sorted_key_record_table.sv
// Start is taken in S_IDLE, S_EXEC decides on the compare, and the result is registered.
// Insert, remove and lookup miss: one result; busy stays high until back in S_IDLE.
// Lookup run of N hits: one result per cycle, busy until the last hit of the run.
// All entries compare in parallel in their cells; all cells shift together.
// Reset clears the entry count and sets max_entries to 32; entries need no clearing.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module sorted_key_record_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  skrt_pkg::req_t req_i,
  output logic           res_valid_o,
  output skrt_pkg::rsp_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [5:0]     cfg_data_i
);
  import skrt_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [5:0]       max_q;
  logic [1:0]       op_mode_q;
  key_t             op_key_q;
  logic [31:0]      op_rec_q;
  logic             res_valid_q, res_valid_d;
  rsp_t             res_q, res_d;

  cell_ctrl_t ctrl;
  logic       accept;
  key_t       cmp_key;
  logic [31:0] cmp_rec;
  logic       pair_mode;

  key_t        key_w [CAPACITY];
  logic [31:0] rec_w [CAPACITY];
  cell_flag_t  flag_w [CAPACITY];

  logic [CAPACITY-1:0] keq_v, peq_v, active_v, fin_v;
  logic        any_keq, any_peq, any_fin, full;
  logic [31:0] hit_rec;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cmp_key     = KEY_BITS'(req_i.key);
  assign pair_mode   = (req_i.mode == MODE_INSERT) || (req_i.mode == MODE_REMOVE);
  assign cmp_rec     = pair_mode ? req_i.record_id : 32'd0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t        lkey, rkey;
    logic [31:0] lrec, rrec;
    logic        llt, lkeq, lact, rkeq;

    if (i == 0) begin : g_head
      assign lkey = op_key_q;
      assign lrec = op_rec_q;
      assign llt  = 1'b1;
      assign lkeq = 1'b0;
      assign lact = 1'b0;
    end else begin : g_body
      assign lkey = key_w[i-1];
      assign lrec = rec_w[i-1];
      assign llt  = flag_w[i-1].lt;
      assign lkeq = flag_w[i-1].keq;
      assign lact = flag_w[i-1].active;
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rkey = op_key_q;
      assign rrec = op_rec_q;
      assign rkeq = 1'b0;
    end else begin : g_inner
      assign rkey = key_w[i+1];
      assign rrec = rec_w[i+1];
      assign rkeq = flag_w[i+1].keq;
    end

    skrt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .occ_i         (CNT_W'(i) < count_q),
      .cmp_key_i     (cmp_key),
      .cmp_rec_i     (cmp_rec),
      .op_key_i      (op_key_q),
      .op_rec_i      (op_rec_q),
      .left_key_i    (lkey),
      .left_rec_i    (lrec),
      .left_lt_i     (llt),
      .left_keq_i    (lkeq),
      .left_active_i (lact),
      .right_key_i   (rkey),
      .right_rec_i   (rrec),
      .right_keq_i   (rkeq),
      .key_o         (key_w[i]),
      .rec_o         (rec_w[i]),
      .flag_o        (flag_w[i])
    );

    assign keq_v[i]    = flag_w[i].keq;
    assign peq_v[i]    = flag_w[i].peq;
    assign active_v[i] = flag_w[i].active;
    assign fin_v[i]    = flag_w[i].fin;
  end

  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_rec = hit_rec | (active_v[i] ? rec_w[i] : 32'd0);
    end
  end

  assign any_keq = |keq_v;
  assign any_peq = |peq_v;
  assign any_fin = |fin_v;
  assign full    = (7'(count_q) >= 7'(max_q)) || (7'(count_q) >= 7'(CAPACITY));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    busy         = 1'b1;
    ctrl         = '0;
    res_valid_d  = 1'b0;
    res_d        = '0;
    res_d.last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy        = 1'b0;
        ctrl.cmp_en = start;
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        unique case (op_mode_q)
          MODE_INSERT: begin
            if (any_peq) begin
              res_d.status = ST_PRESENT;
            end else if (full) begin
              res_d.status = ST_FULL;
            end else begin
              ctrl.ins     = 1'b1;
              count_d      = count_q + 1'b1;
              res_d.status = ST_INSERTED;
            end
          end
          MODE_REMOVE: begin
            if (any_peq) begin
              ctrl.rem     = 1'b1;
              count_d      = count_q - 1'b1;
              res_d.status = ST_REMOVED;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          default: begin
            if (!any_keq) begin
              res_d.status = ST_MISS;
            end else begin
              ctrl.first         = 1'b1;
              ctrl.step          = 1'b1;
              res_d.status       = ST_HIT;
              res_d.found_record = hit_rec;
              res_d.last         = any_fin;
              if (!any_fin) begin
                state_d = S_LOOK;
              end
            end
          end
        endcase
      end
      S_LOOK: begin
        ctrl.step          = 1'b1;
        res_valid_d        = 1'b1;
        res_d.status       = ST_HIT;
        res_d.found_record = hit_rec;
        res_d.last         = any_fin;
        if (any_fin) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_d.entry_count = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      max_q       <= MAX_ENTRIES_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      op_mode_q <= req_i.mode;
      op_key_q  <= cmp_key;
      op_rec_q  <= req_i.record_id;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(active_v))
    else $error("more than one read token active");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(count_q) <= 7'(CAPACITY))
    else $error("entry count beyond capacity");

  a_res_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) != S_IDLE))
    else $error("result without an operation in progress");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == ST_INSERTED)) |->
      (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the table by one");

  a_look_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> (|active_v))
    else $error("lookup run lost its token");

endmodule

### tb/tb_sorted_key_record_table.sv
module tb_sorted_key_record_table;
  timeunit 1ns;
  timeprecision 1ps;

  import skrt_pkg::*;

  // the unused mode encoding, which the block decodes as a lookup
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam int unsigned HIT_LIMIT = 32;
  localparam int unsigned NUM_PHASES = 7;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       res_valid_o;
  rsp_t       res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i;

  // pinned expectation for directed rows whose answer is obvious
  logic pin_v;
  rsp_t pin_rsp;

  sorted_key_record_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------
  logic [31:0] slot_key [CAPACITY];
  logic [31:0] slot_rec [CAPACITY];
  int unsigned n_entries;
  logic [5:0]  entry_limit;
  rsp_t        pending_rsp [$];

  int unsigned err_cnt, ops_cnt, rsp_cnt, hit_cnt, full_cnt, dup_cnt, peak_cnt;

  function automatic int unsigned find_slot(logic [31:0] k, logic [31:0] r);
    int unsigned i;
    i = 0;
    while (i < n_entries && (slot_key[i] < k || (slot_key[i] == k && slot_rec[i] < r)))
      i++;
    return i;
  endfunction

  function automatic rsp_t mk_rsp(status_e s, logic [31:0] rec, logic lst);
    rsp_t o;
    o.status       = s;
    o.found_record = rec;
    o.entry_count  = 6'(n_entries);
    o.last         = lst;
    return o;
  endfunction

  function automatic void post_rsp(rsp_t o);
    pending_rsp = {pending_rsp, o};
  endfunction

  function automatic void table_apply(req_t r);
    int unsigned pos, lim, n, i;
    logic        fin;
    lim = (entry_limit > CAPACITY) ? CAPACITY : entry_limit;
    pos = find_slot(r.key, r.record_id);
    case (r.mode)
      MODE_INSERT: begin
        if (pos < n_entries && slot_key[pos] == r.key && slot_rec[pos] == r.record_id) begin
          post_rsp(mk_rsp(ST_PRESENT, '0, 1'b1));
        end else if (n_entries >= lim) begin
          post_rsp(mk_rsp(ST_FULL, '0, 1'b1));
        end else begin
          for (i = n_entries; i > pos; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_rec[i] = slot_rec[i-1];
          end
          slot_key[pos] = r.key;
          slot_rec[pos] = r.record_id;
          n_entries++;
          post_rsp(mk_rsp(ST_INSERTED, '0, 1'b1));
        end
      end
      MODE_REMOVE: begin
        if (pos < n_entries && slot_key[pos] == r.key && slot_rec[pos] == r.record_id) begin
          for (i = pos; i + 1 < n_entries; i++) begin
            slot_key[i] = slot_key[i+1];
            slot_rec[i] = slot_rec[i+1];
          end
          n_entries--;
          post_rsp(mk_rsp(ST_REMOVED, '0, 1'b1));
        end else begin
          post_rsp(mk_rsp(ST_NOT_FOUND, '0, 1'b1));
        end
      end
      default: begin
        n   = 0;
        pos = find_slot(r.key, '0);
        while (pos < n_entries && slot_key[pos] == r.key && n < HIT_LIMIT) begin
          fin = (pos + 1 >= n_entries) || (n + 1 >= HIT_LIMIT);
          if (!fin) fin = (slot_key[pos+1] != r.key);
          post_rsp(mk_rsp(ST_HIT, slot_rec[pos], fin));
          n++;
          pos++;
        end
        if (n == 0) post_rsp(mk_rsp(ST_MISS, '0, 1'b1));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted commands, compare every result strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    rsp_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) entry_limit = cfg_data_i;

      if (res_valid_o) begin
        rsp_cnt++;
        if (res_o.status == ST_HIT) hit_cnt++;
        if (res_o.status == ST_FULL) full_cnt++;
        if (res_o.status == ST_PRESENT) dup_cnt++;
        if (pending_rsp.size() == 0) begin
          $error("unexpected result: status %0d record %h count %0d",
                 res_o.status, res_o.found_record, res_o.entry_count);
          err_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_o.status);
            err_cnt++;
          end
          if (res_o.found_record !== want.found_record) begin
            $error("found_record: expected %h, got %h", want.found_record, res_o.found_record);
            err_cnt++;
          end
          if (res_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, res_o.entry_count);
            err_cnt++;
          end
          if (res_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_o.last);
            err_cnt++;
          end
        end
      end

      if (start && !busy) begin
        ops_cnt++;
        table_apply(req_i);
        if (pin_v) begin
          pending_rsp[pending_rsp.size() - 1] = pin_rsp;
        end
        if (n_entries > peak_cnt) peak_cnt = n_entries;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t        rq;
    logic        pin;
    status_e     st;
    logic [5:0]  cnt;
  } dir_row_t;

  dir_row_t dir_tab [$];

  int unsigned ph_limit [NUM_PHASES] = '{0, 1, 32, 63, 4, 32, 17};
  int unsigned ph_idle  [NUM_PHASES] = '{0, 80, 17, 0, 80, 17, 0};
  int unsigned ph_ins   [NUM_PHASES] = '{50, 50, 65, 60, 20, 55, 40};
  int unsigned ph_rem   [NUM_PHASES] = '{20, 20, 15, 15, 45, 25, 30};
  int unsigned ph_items [NUM_PHASES] = '{30, 40, 120, 60, 50, 60, 50};

  task automatic add_row(logic [1:0] m, logic [31:0] k, logic [31:0] r,
                         logic p = 1'b0, status_e s = ST_MISS, logic [5:0] c = '0);
    dir_row_t row;
    row.rq.mode      = m;
    row.rq.key       = k;
    row.rq.record_id = r;
    row.pin          = p;
    row.st           = s;
    row.cnt          = c;
    dir_tab = {dir_tab, row};
  endtask

  // one command transaction; the sender idles each cycle with the given odds
  task automatic issue(req_t r, logic pv, rsp_t pr, int unsigned idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    req_i   <= r;
    pin_v   <= pv;
    pin_rsp <= pr;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every predicted result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [5:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(4) == 0) return $urandom;
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      4: return 32'h5A5A_0000;
      5: return 32'h5A5A_0001;
      6: return 32'h7FFF_FFFF;
      default: return 32'h0000_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_rec();
    if ($urandom_range(3) == 0) return $urandom;
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic req_t make_op(int unsigned ins_pct, int unsigned rem_pct);
    req_t        r;
    int unsigned roll, idx;
    roll = $urandom_range(99);
    if (roll < ins_pct) r.mode = MODE_INSERT;
    else if (roll < ins_pct + rem_pct) r.mode = MODE_REMOVE;
    else if (roll < 95) r.mode = MODE_LOOKUP;
    else r.mode = MODE_ALIAS;
    r.key       = pick_key();
    r.record_id = pick_rec();
    // aim removes and lookups at stored pairs most of the time
    if (n_entries > 0 && r.mode != MODE_INSERT && $urandom_range(3) != 0) begin
      idx   = $urandom_range(n_entries - 1);
      r.key = slot_key[idx];
      if (r.mode == MODE_REMOVE) r.record_id = slot_rec[idx];
    end
    return r;
  endfunction

  initial begin : stim
    rsp_t        pr;
    req_t        rq;
    int unsigned ph, j;

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    pin_v       = 1'b0;
    pin_rsp     = '0;
    n_entries   = 0;
    entry_limit = MAX_ENTRIES_RST;
    err_cnt = 0; ops_cnt = 0; rsp_cnt = 0; hit_cnt = 0;
    full_cnt = 0; dup_cnt = 0; peak_cnt = 0;

    add_row(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS, 6'd0);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_MISS, 6'd0);
    add_row(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd0);
    add_row(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_INSERTED, 6'd1);
    add_row(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_PRESENT, 6'd1);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 6'd2);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_INSERTED, 6'd3);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, ST_INSERTED, 6'd4);
    add_row(MODE_INSERT, 32'h8000_0000, 32'h0000_0001, 1'b1, ST_INSERTED, 6'd5);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_row(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    add_row(MODE_ALIAS,  32'hFFFF_FFFF, 32'h1234_5678);
    add_row(MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000, 1'b1, ST_MISS, 6'd5);
    add_row(MODE_REMOVE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, ST_REMOVED, 6'd4);
    add_row(MODE_REMOVE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, ST_NOT_FOUND, 6'd4);
    add_row(MODE_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd4);
    add_row(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 6'd5);
    add_row(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_row(MODE_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b1, ST_INSERTED, 6'd6);
    add_row(MODE_INSERT, 32'h7FFF_FFFF, 32'h5555_5555, 1'b1, ST_INSERTED, 6'd7);
    add_row(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    add_row(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_REMOVED, 6'd6);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      pr.status       = dir_tab[i].st;
      pr.found_record = '0;
      pr.entry_count  = dir_tab[i].cnt;
      pr.last         = 1'b1;
      issue(dir_tab[i].rq, dir_tab[i].pin, pr, 0);
    end

    // phases walk the limit through zero, one, the saturating top code and
    // values below the current fill, under different sender idling
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      set_limit(6'(ph_limit[ph]));
      for (j = 0; j < ph_items[ph]; j++) begin
        rq = make_op(ph_ins[ph], ph_rem[ph]);
        issue(rq, 1'b0, '0, ph_idle[ph]);
        if ($urandom_range(49) == 0) settle();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d expected results never arrived", pending_rsp.size());
      err_cnt++;
    end

    $display("Covered %0d commands and %0d results over %0d limit settings", ops_cnt,
             rsp_cnt, NUM_PHASES);
    $display("  %0d lookup hits, %0d full, %0d already present, peak fill %0d",
             hit_cnt, full_cnt, dup_cnt, peak_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
